// ===== sv/cd2s_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cd2s_pkg
// Shared constants and helpers for the calendar date to seconds converter.
// ----------------------------------------------------------------------------
package cd2s_pkg;

	// Epoch: 1 January of this year, 00:00:00
	localparam int EPOCH_YEAR_INT = 2014;
	localparam logic [11:0] EPOCH_YEAR = 12'(EPOCH_YEAR_INT);

	// Leap years from year 1 through the year before the epoch
	localparam int LEAPS_BEFORE_EPOCH = (EPOCH_YEAR_INT - 1) / 4
		- (EPOCH_YEAR_INT - 1) / 100 + (EPOCH_YEAR_INT - 1) / 400;

	// x / 100 as (x * 5243) >> 19, exact for x below 43690
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SH = 19;

	localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
	localparam logic [6:0]  YEARS_PER_CENT = 7'd100;
	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [3:0]  MONTH_FEB = 4'd2;

	// Days in the completed months of a common year
	function automatic logic [8:0] cum_days(input logic [3:0] done);
		logic [8:0] d;
		case (done)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd365;
		endcase
		return d;
	endfunction

	// Completed months of the year, clamped to 0..12
	function automatic logic [3:0] done_months(input logic [3:0] month);
		logic [3:0] d;
		if (month == 4'd0) begin
			d = 4'd0;
		end else if (month > 4'd12) begin
			d = 4'd12;
		end else begin
			d = month - 4'd1;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== sv/cd2s_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cd2s_date_if / cd2s_result_if
// Valid/ready channels carrying a date request and its seconds result.
// ----------------------------------------------------------------------------
interface cd2s_date_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	modport source (output valid, year, month, day, hour, minute, second, input ready);
	modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface cd2s_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] seconds_since_epoch;

	modport source (output valid, seconds_since_epoch, input ready);
	modport sink   (input valid, seconds_since_epoch, output ready);
endinterface
`default_nettype wire

// ===== sv/calendar_date_to_seconds.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_to_seconds
// A request passes through the registers of stages 1 to 5; stage 5 drives the output.
// Throughput: one request per cycle while the output is not stalled; the five-stage
// pipeline with the 32-bit day-to-seconds multiplier in its own stage sets the clock period.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) clears all stage valid bits.
// Converts a calendar date and time to seconds since the epoch year start.
// ----------------------------------------------------------------------------
module calendar_date_to_seconds (
	input  wire logic    clk,
	input  wire logic    arst_n,
	cd2s_date_if.sink    date,
	cd2s_result_if.source result
);
	import cd2s_pkg::*;

	// Pipeline advances whenever the output stage is free or being taken
	logic adv;
	assign adv = !result.valid || result.ready;
	assign date.ready = adv;

	// Stage 1: year offsets and quotients by 100
	logic [11:0] ym1;
	logic [24:0] prod_ym1, prod_yr;
	assign ym1      = date.year - 12'd1;
	assign prod_ym1 = {13'd0, ym1} * {12'd0, DIV100_MUL};
	assign prod_yr  = {13'd0, date.year} * {12'd0, DIV100_MUL};

	logic        v_s1;
	logic [11:0] ym1_s1, year_s1, yrs_s1;
	logic [5:0]  q_ym1_s1, q_yr_s1;
	logic [3:0]  done_s1;
	logic [4:0]  day_s1, hour_s1;
	logic [5:0]  minute_s1, second_s1;

	// Stage 2: leap count, leap flag, whole-year days, month days, time of day
	logic [10:0] leaps_raw;
	logic [12:0] cent_mul;
	logic        is_cent, leap_now;
	assign leaps_raw = {1'b0, ym1_s1[11:2]} - {5'd0, q_ym1_s1} + {7'd0, q_ym1_s1[5:2]}
		- 11'(LEAPS_BEFORE_EPOCH);
	assign cent_mul  = {7'd0, q_yr_s1} * {6'd0, YEARS_PER_CENT};
	assign is_cent   = (cent_mul[11:0] == year_s1);
	assign leap_now  = is_cent ? (q_yr_s1[1:0] == 2'd0) : (year_s1[1:0] == 2'd0);

	logic        v_s2;
	logic [10:0] leaps_s2;
	logic [20:0] ydays_s2;
	logic [8:0]  mbase_s2;
	logic        madj_s2;
	logic [4:0]  day_s2;
	logic [16:0] hms_s2;

	// Stage 3: total day count, wrapping at 32 bits
	logic        v_s3;
	logic [31:0] days_s3;
	logic [16:0] hms_s3;

	// Stage 4: days to seconds
	logic        v_s4;
	logic [31:0] dsec_s4;
	logic [16:0] hms_s4;

	// Stage 5: output register
	logic        v_s5;
	logic [31:0] sec_s5;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= date.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			ym1_s1    <= ym1;
			year_s1   <= date.year;
			yrs_s1    <= (date.year > EPOCH_YEAR) ? (date.year - EPOCH_YEAR) : 12'd0;
			q_ym1_s1  <= prod_ym1[DIV100_SH +: 6];
			q_yr_s1   <= prod_yr[DIV100_SH +: 6];
			done_s1   <= done_months(date.month);
			day_s1    <= date.day;
			hour_s1   <= date.hour;
			minute_s1 <= date.minute;
			second_s1 <= date.second;

			leaps_s2 <= (yrs_s1 == 12'd0) ? 11'd0 : leaps_raw;
			ydays_s2 <= {9'd0, yrs_s1} * {12'd0, DAYS_PER_YEAR};
			mbase_s2 <= cum_days(done_s1);
			madj_s2  <= leap_now && (done_s1 >= MONTH_FEB);
			day_s2   <= day_s1;
			hms_s2   <= {12'd0, hour_s1} * {5'd0, SECS_PER_HOUR}
				+ {11'd0, minute_s1} * {11'd0, SECS_PER_MIN}
				+ {11'd0, second_s1};

			days_s3 <= {11'd0, ydays_s2} + {21'd0, leaps_s2} + {23'd0, mbase_s2}
				+ {31'd0, madj_s2} + {27'd0, day_s2} - 32'd1;
			hms_s3  <= hms_s2;

			dsec_s4 <= days_s3 * SECS_PER_DAY;
			hms_s4  <= hms_s3;

			sec_s5 <= dsec_s4 + {15'd0, hms_s4};
		end
	end

	assign result.valid               = v_s5;
	assign result.seconds_since_epoch = sec_s5;

	// Checks
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5}))
		else $error("stage valid bits moved during a stall");
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (result.valid == $past(v_s4)))
		else $error("output valid does not follow stage 4");
	a_no_years: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && yrs_s1 == 12'd0) |=> (leaps_s2 == 11'd0 && ydays_s2 == 21'd0))
		else $error("whole-year days counted for a year at or before the epoch");
	a_feb_adj: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && madj_s2) |-> (mbase_s2 >= 9'd59))
		else $error("leap day added before February completed");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: calendar date to seconds converter
// Feeds date requests to the converter and checks every seconds result, in
// order, against a behavioral model. The run starts with hand-picked edge
// dates, then moves to random dates, mostly well formed. Both handshake
// sides idle in random bursts, and the final stretch runs at full rate.
// ----------------------------------------------------------------------------
module tb;

	localparam int EPOCH         = cd2s_pkg::EPOCH_YEAR_INT;
	localparam int LAST_YEAR     = 2149;
	localparam int FEBRUARY      = 2;
	localparam int RANDOM_COUNT  = 1500;
	localparam int QUIET_COUNT   = 150;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} date_t;

	typedef struct {
		date_t       date;
		logic [31:0] seconds;
	} pending_t;

	logic clk;
	logic arst_n;
	bit   quiet_tail;
	int   stall_left;
	int   idle_cycles;

	cd2s_date_if   date_bus();
	cd2s_result_if secs_bus();

	calendar_date_to_seconds dut (
		.clk    (clk),
		.arst_n (arst_n),
		.date   (date_bus),
		.result (secs_bus)
	);

	// Gregorian leap rule
	function automatic bit is_leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
		int unsigned lengths[13];
		lengths = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == FEBRUARY && is_leap_year(y)) begin
			return 29;
		end
		return lengths[m];
	endfunction

	// Expected seconds per accepted request, oldest first
	class seconds_board;
		pending_t pending_seconds[$];
		int       requests;
		int       checked;
		int       errors;

		function new();
			requests = 0;
			checked  = 0;
			errors   = 0;
		endfunction

		// Seconds since the epoch, all sums modulo 2^32
		function logic [31:0] date_to_seconds(input date_t d);
			logic [31:0] total;
			int unsigned y;
			int unsigned full_months;
			total = 32'd0;
			for (y = EPOCH; y < d.year; y++) begin
				total += is_leap_year(y) ? 32'd366 * 32'd86400 : 32'd365 * 32'd86400;
			end
			// month zero counts nothing, months past December count the whole year
			if (d.month == 4'd0) begin
				full_months = 0;
			end else if (d.month > 4'd12) begin
				full_months = 12;
			end else begin
				full_months = d.month - 1;
			end
			for (int unsigned m = 1; m <= full_months; m++) begin
				total += 32'(month_length(d.year, m)) * 32'd86400;
			end
			// day zero takes one day off
			total += (32'(d.day) - 32'd1) * 32'd86400;
			total += 32'(d.hour) * 32'd3600;
			total += 32'(d.minute) * 32'd60;
			total += 32'(d.second);
			return total;
		endfunction

		function void note_request(input date_t d);
			pending_t p;
			p.date    = d;
			p.seconds = date_to_seconds(d);
			pending_seconds.push_back(p);
			requests++;
		endfunction

		function void check_result(input logic [31:0] got);
			pending_t p;
			if (pending_seconds.size() == 0) begin
				$display("%0t: unexpected result: expected none, got %0d", $time, got);
				errors++;
				return;
			end
			p = pending_seconds.pop_front();
			checked++;
			if (got !== p.seconds) begin
				$display("%0t: seconds for %0d-%0d-%0d %0d:%0d:%0d: expected %0d, got %0d",
					$time, p.date.year, p.date.month, p.date.day, p.date.hour,
					p.date.minute, p.date.second, p.seconds, got);
				errors++;
			end
		endfunction
	endclass

	seconds_board board;

	// Clock and inputs at known values from time zero
	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		date_bus.valid   = 1'b0;
		date_bus.year    = '0;
		date_bus.month   = '0;
		date_bus.day     = '0;
		date_bus.hour    = '0;
		date_bus.minute  = '0;
		date_bus.second  = '0;
		secs_bus.ready   = 1'b0;
		quiet_tail       = 1'b0;
		stall_left       = 0;
		idle_cycles      = 0;
	end

	always #1 clk = ~clk;

	// Result side: ready drops in random bursts until the quiet tail
	always @(posedge clk) begin
		if (stall_left != 0) begin
			secs_bus.ready <= 1'b0;
			stall_left     <= stall_left - 1;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			secs_bus.ready <= 1'b0;
			stall_left     <= $urandom_range(0, 17);
		end else begin
			secs_bus.ready <= 1'b1;
		end
	end

	// Watch both channels; end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if (date_bus.valid && date_bus.ready) begin
				board.note_request({date_bus.year, date_bus.month, date_bus.day,
					date_bus.hour, date_bus.minute, date_bus.second});
			end
			if (secs_bus.valid && secs_bus.ready) begin
				board.check_result(secs_bus.seconds_since_epoch);
			end
			if ((date_bus.valid && date_bus.ready) || (secs_bus.valid && secs_bus.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("tb: done, errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// One request, with an optional random gap ahead of it
	task automatic send_date(input date_t d);
		int gap;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			date_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		date_bus.valid  <= 1'b1;
		date_bus.year   <= d.year;
		date_bus.month  <= d.month;
		date_bus.day    <= d.day;
		date_bus.hour   <= d.hour;
		date_bus.minute <= d.minute;
		date_bus.second <= d.second;
		do @(posedge clk); while (!date_bus.ready);
	endtask

	task automatic send_fields(input int y, input int mo, input int d, input int h,
		input int mi, input int s);
		send_date({12'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s)});
	endtask

	// Mostly valid dates; some with fields over their range, some pure noise
	function automatic date_t random_date();
		date_t d;
		int    pick;
		pick     = $urandom_range(0, 9);
		d.year   = 12'($urandom_range(EPOCH, LAST_YEAR));
		d.month  = 4'($urandom_range(1, 12));
		d.day    = 5'($urandom_range(1, month_length(d.year, d.month)));
		d.hour   = 5'($urandom_range(0, 23));
		d.minute = 6'($urandom_range(0, 59));
		d.second = 6'($urandom_range(0, 59));
		if (pick >= 8) begin
			d.month  = 4'($urandom_range(0, 15));
			d.day    = 5'($urandom_range(0, 31));
			d.hour   = 5'($urandom_range(0, 31));
			d.minute = 6'($urandom_range(0, 63));
			d.second = 6'($urandom_range(0, 63));
		end
		if (pick == 9) begin
			d.year = 12'($urandom_range(0, 4095));
		end
		return d;
	endfunction

	initial begin
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge dates
		send_fields(2014, 1, 1, 0, 0, 0);
		send_fields(2014, 12, 31, 23, 59, 59);
		send_fields(2016, 2, 29, 12, 0, 0);
		send_fields(2016, 3, 1, 0, 0, 0);
		send_fields(2100, 3, 1, 0, 0, 0);
		send_fields(2149, 12, 31, 23, 59, 59);
		send_fields(2150, 1, 1, 0, 0, 0);
		send_fields(2013, 1, 1, 0, 0, 0);
		send_fields(2000, 3, 1, 6, 30, 15);
		send_fields(1900, 3, 1, 0, 0, 0);
		send_fields(0, 0, 0, 0, 0, 0);
		send_fields(2014, 1, 0, 0, 0, 0);
		send_fields(2014, 0, 1, 0, 0, 1);
		send_fields(2020, 13, 1, 0, 0, 0);
		send_fields(2021, 15, 31, 23, 59, 59);
		send_fields(2019, 2, 31, 0, 0, 0);
		send_fields(2048, 7, 16, 31, 63, 63);
		send_fields(2024, 2, 29, 23, 59, 59);
		send_fields(2400, 6, 15, 12, 0, 0);
		send_fields(4095, 15, 31, 31, 63, 63);
		send_fields(2730, 10, 21, 17, 42, 7);

		// Random dates; the final stretch runs with no idling
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i == RANDOM_COUNT - QUIET_COUNT) begin
				quiet_tail = 1'b1;
			end
			send_date(random_date());
		end
		date_bus.valid <= 1'b0;

		// Drain, then let the pipeline settle
		while (board.pending_seconds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tb: %0d date requests sent, %0d seconds results checked", board.requests,
			board.checked);
		$display("tb: edge dates, out-of-range fields and random dates with stalls on both sides");
		if (board.errors == 0 && board.pending_seconds.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/cd2s_pkg.sv
sv/cd2s_if.sv
sv/calendar_date_to_seconds.sv
sim/tb.sv
